@@ hdl/wps_pkg.sv @@
// Package for the wavefunction position statistics block.
// Holds payload structs, register indexes, shift amounts and the sequencer states.
// No dependencies; the core, front, back and testbench use it.
package wps_pkg;

  localparam int SampleBits        = 16;
  localparam int PosBits           = 16;
  localparam int MaxSamplesDefault = 1024;

  localparam int CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] CFG_GRID_STEP     = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_INTERVAL_LOW  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_INTERVAL_HIGH = 2'd2;

  localparam logic [15:0]        GridStepReset     = 16'd256;
  localparam logic signed [15:0] IntervalLowReset  = -16'sd32768;
  localparam logic signed [15:0] IntervalHighReset = 16'sd32767;

  // Fraction bits dropped when a sum is scaled by the grid step.
  localparam int ShNorm   = 6;
  localparam int ShFirst  = 14;
  localparam int ShSecond = 22;

  typedef struct packed {
    logic signed [SampleBits-1:0] psi_re;
    logic signed [SampleBits-1:0] psi_im;
    logic signed [PosBits-1:0]    position;
    logic                         last_sample;
  } in_item_t;

  typedef struct packed {
    logic [47:0]        norm_squared;
    logic [31:0]        inverse_norm;
    logic [47:0]        interval_probability;
    logic signed [47:0] mean_position;
    logic [47:0]        mean_square_position;
    logic [31:0]        position_spread;
    logic               norm_zero;
    logic               variance_negative;
    logic [10:0]        samples_seen;
  } out_item_t;

  // Classified sample as it waits between front and back.
  typedef struct packed {
    logic [31:0]               sq;
    logic signed [PosBits-1:0] position;
    logic                      in_interval;
    logic                      last_sample;
  } q_item_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_PROD1,
    BS_PROD2,
    BS_ACC,
    BS_SCALE,
    BS_SQR,
    BS_VAR,
    BS_SQV,
    BS_WDIV,
    BS_SQI,
    BS_OUT
  } back_state_t;

endpackage

@@ hdl/wavefunction_position_statistics_core.sv @@
// Top level of the wavefunction position statistics block.
// Holds the configuration registers and joins wps_front and wps_back. Uses wps_pkg.
//
// Usage: samples enter on in_valid/in_ready as in_data (psi_re, psi_im, position,
// last_sample); each accepted transaction adds to the norm, first and second sums,
// and to the interval sum if its position lies inside. The transaction with
// last_sample set makes one result on out_valid/out_ready and clears the sums.
// Configuration registers (grid step, interval bounds) are written through
// cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high and
// writes are meant for idle periods. The back part pops, multiplies and
// accumulates each sample before it takes the next; a two-entry queue lets the
// front take samples while the back is busy. After the last sample the back part
// scales the sums, squares the mean and runs the 65-step divider followed by the
// 32-step square root before it offers the result.
// Reset (rst_n low, synchronous) clears sums, count, queue and the result valid
// flag and loads the register reset values. While the receiver stalls the
// result is held; samples are still taken until the queue fills.
module wavefunction_position_statistics_core #(
  parameter int MAX_SAMPLES = wps_pkg::MaxSamplesDefault
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  wps_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output wps_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wps_pkg::CfgIdxBits-1:0]      cfg_index,
  input  logic [15:0]                         cfg_data
);

  logic [15:0]        grid_r;
  logic signed [15:0] ilow_r;
  logic signed [15:0] ihigh_r;
  logic               q_valid;
  logic               q_pop;
  wps_pkg::q_item_t   q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r  <= wps_pkg::GridStepReset;
      ilow_r  <= wps_pkg::IntervalLowReset;
      ihigh_r <= wps_pkg::IntervalHighReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wps_pkg::CFG_GRID_STEP:     grid_r  <= cfg_data;
        wps_pkg::CFG_INTERVAL_LOW:  ilow_r  <= $signed(cfg_data);
        wps_pkg::CFG_INTERVAL_HIGH: ihigh_r <= $signed(cfg_data);
        default: begin
          grid_r <= grid_r;
        end
      endcase
    end
  end

  wps_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .interval_low  (ilow_r),
    .interval_high (ihigh_r),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_data        (q_data)
  );

  wps_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .grid_step (grid_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hdl/wps_front.sv @@
// Front part: accepts samples, forms |psi|^2 and the interval flag,
// and holds them in a two-entry queue for the back part. Uses wps_pkg.
module wps_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  wps_pkg::in_item_t      in_data,
  input  logic signed [15:0]     interval_low,
  input  logic signed [15:0]     interval_high,
  output logic                   q_valid,
  input  logic                   q_pop,
  output wps_pkg::q_item_t       q_data
);

  wps_pkg::q_item_t   mem_r [2];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         cnt_r;
  logic               push;
  logic signed [31:0] re2;
  logic signed [31:0] im2;
  wps_pkg::q_item_t   item_c;

  assign re2 = in_data.psi_re * in_data.psi_re;
  assign im2 = in_data.psi_im * in_data.psi_im;

  always_comb begin
    item_c.sq          = 32'(re2) + 32'(im2);
    item_c.position    = in_data.position;
    item_c.in_interval = (in_data.position >= interval_low) &&
                         (in_data.position <= interval_high);
    item_c.last_sample = in_data.last_sample;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ hdl/wps_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
// Gives floor(sqrt(operand)) for a 64-bit operand. Uses no package items.
module wps_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] operand,
  output logic        busy,
  output logic [31:0] root
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [63:0] v_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [35:0] rem_s;
  logic [35:0] trial;
  logic        take;

  assign rem_s = {rem_r, v_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};
  assign take  = (rem_s >= trial);
  assign busy  = busy_r;
  assign root  = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= operand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[61:0], 2'b00};
      rem_r  <= take ? 34'(rem_s - trial) : rem_s[33:0];
      root_r <= {root_r[30:0], take};
    end
  end

endmodule

@@ hdl/wps_div.sv @@
// Restoring divider that forms floor(2^64 / divisor), one quotient bit per cycle.
// The quotient stays valid until the next start. No package items.
module wps_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] divisor,
  output logic        busy,
  output logic [64:0] quotient
);

  logic        busy_r;
  logic [6:0]  cnt_r;
  logic [47:0] rem_r;
  logic [64:0] dq_r;
  logic [47:0] dsr_r;
  logic [48:0] rem_s;
  logic        take;

  assign rem_s    = {rem_r, dq_r[64]};
  assign take     = (rem_s >= {1'b0, dsr_r});
  assign busy     = busy_r;
  assign quotient = dq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd65;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= {1'b1, 64'd0};
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? 48'(rem_s - {1'b0, dsr_r}) : rem_s[47:0];
      dq_r  <= {dq_r[63:0], take};
    end
  end

endmodule

@@ hdl/wps_back.sv @@
// Back part: moment products, saturating accumulators and the final sequencer
// with a shared 32x32 multiplier, square root and divider. Uses wps_pkg,
// wps_isqrt and wps_div.
module wps_back #(
  parameter int MAX_SAMPLES = wps_pkg::MaxSamplesDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  wps_pkg::q_item_t    q_data,
  input  logic [15:0]         grid_step,
  output logic                out_valid,
  input  logic                out_ready,
  output wps_pkg::out_item_t  out_data
);

  localparam int CntW = $clog2(MAX_SAMPLES + 1);

  wps_pkg::back_state_t state_r, state_nxt;

  logic [31:0]        sq_r;
  logic signed [15:0] x_r;
  logic               in_int_r;
  logic               last_r;
  logic signed [48:0] xp_r;
  logic [31:0]        ax2_r;
  logic [61:0]        x2p_r;
  logic [15:0]        ax;

  logic [41:0]        prob_r;
  logic [41:0]        int_r;
  logic signed [57:0] fm_r;
  logic [63:0]        sm_r;
  logic [CntW-1:0]    cnt_r;

  logic [42:0]        prob_s;
  logic [42:0]        int_s;
  logic signed [58:0] fm_s;
  logic [64:0]        sm_s;

  logic [1:0]  op_r;
  logic [1:0]  ph_r;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p_r;
  logic [63:0] lo_r;
  logic [63:0] opnd;
  logic [57:0] fm_mag;
  logic [95:0] full_c;
  logic [95:0] shifted;
  logic [47:0] cap;
  logic [47:0] scaled;

  logic [47:0] nrm_r;
  logic [47:0] ipr_r;
  logic [47:0] msq_r;
  logic [47:0] mmag_r;
  logic        mneg_r;
  logic [63:0] m2_r;
  logic        neg_r;
  logic        neg_c;
  logic [47:0] var_c;
  logic [31:0] spread_r;
  logic [31:0] inv_r;

  logic        sq_start;
  logic        div_start;
  logic        load;
  logic        sq_busy;
  logic        div_busy;
  logic [63:0] sq_opnd;
  logic [31:0] sq_root;
  logic [64:0] div_q;

  logic                  out_valid_r;
  wps_pkg::out_item_t    out_data_r;
  logic [CntW+10:0]      cnt_ext;

  wps_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .operand (sq_opnd),
    .busy    (sq_busy),
    .root    (sq_root)
  );

  wps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (nrm_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wps_pkg::BS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    sq_start  = 1'b0;
    div_start = 1'b0;
    load      = 1'b0;
    case (state_r)
      wps_pkg::BS_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = wps_pkg::BS_PROD1;
        end
      end
      wps_pkg::BS_PROD1: state_nxt = wps_pkg::BS_PROD2;
      wps_pkg::BS_PROD2: state_nxt = wps_pkg::BS_ACC;
      wps_pkg::BS_ACC: begin
        state_nxt = last_r ? wps_pkg::BS_SCALE : wps_pkg::BS_IDLE;
      end
      wps_pkg::BS_SCALE: begin
        if (ph_r == 2'd2 && op_r == 2'd3) begin
          state_nxt = wps_pkg::BS_SQR;
        end
      end
      wps_pkg::BS_SQR: begin
        if (ph_r == 2'd3) begin
          state_nxt = wps_pkg::BS_VAR;
        end
      end
      wps_pkg::BS_VAR: begin
        sq_start  = 1'b1;
        div_start = 1'b1;
        state_nxt = wps_pkg::BS_SQV;
      end
      wps_pkg::BS_SQV: begin
        if (!sq_busy) begin
          state_nxt = wps_pkg::BS_WDIV;
        end
      end
      wps_pkg::BS_WDIV: begin
        if (!div_busy) begin
          sq_start  = 1'b1;
          state_nxt = wps_pkg::BS_SQI;
        end
      end
      wps_pkg::BS_SQI: begin
        if (!sq_busy) begin
          state_nxt = wps_pkg::BS_OUT;
        end
      end
      wps_pkg::BS_OUT: begin
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          state_nxt = wps_pkg::BS_IDLE;
        end
      end
      default: state_nxt = wps_pkg::BS_IDLE;
    endcase
  end

  // ---------------- per-sample products ----------------
  assign ax = x_r[15] ? 16'(-x_r) : 16'(x_r);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sq_r     <= q_data.sq;
      x_r      <= q_data.position;
      in_int_r <= q_data.in_interval;
      last_r   <= q_data.last_sample;
    end
    if (state_r == wps_pkg::BS_PROD1) begin
      xp_r  <= 49'(x_r) * 49'($signed({1'b0, sq_r}));
      ax2_r <= 32'(ax) * 32'(ax);
    end
    if (state_r == wps_pkg::BS_PROD2) begin
      x2p_r <= 62'(ax2_r) * 62'(sq_r);
    end
  end

  // ---------------- accumulators ----------------
  assign prob_s = {1'b0, prob_r} + 43'(sq_r);
  assign int_s  = {1'b0, int_r} + 43'(sq_r);
  assign fm_s   = 59'(fm_r) + 59'(xp_r);
  assign sm_s   = {1'b0, sm_r} + 65'(x2p_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prob_r <= '0;
      int_r  <= '0;
      fm_r   <= '0;
      sm_r   <= '0;
      cnt_r  <= '0;
    end else if (load) begin
      prob_r <= '0;
      int_r  <= '0;
      fm_r   <= '0;
      sm_r   <= '0;
      cnt_r  <= '0;
    end else if (state_r == wps_pkg::BS_ACC) begin
      prob_r <= prob_s[42] ? {42{1'b1}} : prob_s[41:0];
      if (in_int_r) begin
        int_r <= int_s[42] ? {42{1'b1}} : int_s[41:0];
      end
      // The sum fits 58 bits exactly when its two top bits agree.
      case (fm_s[58:57])
        2'b01:   fm_r <= {1'b0, {57{1'b1}}};
        2'b10:   fm_r <= {1'b1, 57'd0};
        default: fm_r <= fm_s[57:0];
      endcase
      sm_r <= sm_s[64] ? {64{1'b1}} : sm_s[63:0];
      if (cnt_r < CntW'(MAX_SAMPLES)) begin
        cnt_r <= cnt_r + CntW'(1);
      end
    end
  end

  // ---------------- final scaling on the shared multiplier ----------------
  assign fm_mag = fm_r[57] ? 58'(-fm_r) : 58'(fm_r);

  always_comb begin
    case (op_r)
      2'd0:    opnd = 64'(prob_r);
      2'd1:    opnd = 64'(int_r);
      2'd2:    opnd = sm_r;
      default: opnd = 64'(fm_mag);
    endcase
  end

  always_comb begin
    mul_a = opnd[31:0];
    mul_b = 32'(grid_step);
    if (state_r == wps_pkg::BS_SCALE) begin
      if (ph_r != 2'd0) begin
        mul_a = opnd[63:32];
      end
    end else begin
      // Square of the mean magnitude from its 32-bit low and 16-bit high parts.
      case (ph_r)
        2'd0: begin
          mul_a = mmag_r[31:0];
          mul_b = mmag_r[31:0];
        end
        2'd1: begin
          mul_a = 32'(mmag_r[47:32]);
          mul_b = mmag_r[31:0];
        end
        default: begin
          mul_a = 32'(mmag_r[47:32]);
          mul_b = 32'(mmag_r[47:32]);
        end
      endcase
    end
  end

  assign full_c = 96'(lo_r) + {mul_p_r, 32'd0};

  always_comb begin
    cap = {48{1'b1}};
    case (op_r)
      2'd0, 2'd1: shifted = full_c >> wps_pkg::ShNorm;
      2'd2:       shifted = full_c >> wps_pkg::ShSecond;
      default: begin
        shifted = full_c >> wps_pkg::ShFirst;
        cap     = fm_r[57] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end
    endcase
    scaled = (shifted > 96'(cap)) ? cap : shifted[47:0];
  end

  assign neg_c = (m2_r > 64'(msq_r));
  assign var_c = neg_c ? 48'd0 : 48'(64'(msq_r) - m2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= 2'd0;
      ph_r <= 2'd0;
    end else begin
      case (state_r)
        wps_pkg::BS_ACC: begin
          op_r <= 2'd0;
          ph_r <= 2'd0;
        end
        wps_pkg::BS_SCALE: begin
          if (ph_r == 2'd2) begin
            ph_r <= 2'd0;
            op_r <= op_r + 2'd1;
          end else begin
            ph_r <= ph_r + 2'd1;
          end
        end
        wps_pkg::BS_SQR: ph_r <= ph_r + 2'd1;
        default: begin
          op_r <= op_r;
          ph_r <= ph_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
    if (state_r == wps_pkg::BS_SCALE) begin
      if (ph_r == 2'd1) begin
        lo_r <= mul_p_r;
      end
      if (ph_r == 2'd2) begin
        case (op_r)
          2'd0: nrm_r <= scaled;
          2'd1: ipr_r <= scaled;
          2'd2: msq_r <= scaled;
          default: begin
            mmag_r <= scaled;
            mneg_r <= fm_r[57];
          end
        endcase
      end
    end
    if (state_r == wps_pkg::BS_SQR) begin
      case (ph_r)
        2'd1:    m2_r <= 64'(mul_p_r[63:32]);
        2'd2:    m2_r <= m2_r + {mul_p_r[62:0], 1'b0};
        2'd3:    m2_r <= m2_r + {mul_p_r[31:0], 32'd0};
        default: m2_r <= m2_r;
      endcase
    end
    if (state_r == wps_pkg::BS_VAR) begin
      neg_r <= neg_c;
    end
    if (state_r == wps_pkg::BS_SQV && !sq_busy) begin
      spread_r <= sq_root;
    end
    if (state_r == wps_pkg::BS_SQI && !sq_busy) begin
      if (nrm_r == 48'd0) begin
        inv_r <= 32'd0;
      end else if (nrm_r == 48'd1) begin
        inv_r <= {32{1'b1}};
      end else begin
        inv_r <= sq_root;
      end
    end
  end

  assign sq_opnd = (state_r == wps_pkg::BS_WDIV) ? div_q[63:0] : 64'(var_c);

  // ---------------- result register ----------------
  assign cnt_ext = (CntW + 11)'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.norm_squared         <= nrm_r;
      out_data_r.inverse_norm         <= inv_r;
      out_data_r.interval_probability <= ipr_r;
      out_data_r.mean_position        <= mneg_r ? 48'(48'd0 - mmag_r) : mmag_r;
      out_data_r.mean_square_position <= msq_r;
      out_data_r.position_spread      <= spread_r;
      out_data_r.norm_zero            <= (nrm_r == 48'd0);
      out_data_r.variance_negative    <= neg_r;
      out_data_r.samples_seen         <= cnt_ext[10:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == wps_pkg::BS_IDLE)
    else $error("queue popped outside idle");

  a_zero_norm_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.norm_zero |-> out_data_r.inverse_norm == 32'd0)
    else $error("zero norm with nonzero inverse");

  a_neg_var_spread: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.variance_negative |-> out_data_r.position_spread == 32'd0)
    else $error("negative variance with nonzero spread");

  a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> prob_r == '0 && sm_r == '0 && cnt_r == '0)
    else $error("sums not cleared after result");
`endif

endmodule

@@ tb/wavefunction_position_statistics_core_tb.sv @@
// Testbench for wavefunction_position_statistics_core: a scoreboard class predicts
// the moment sums and final statistics for each wavefunction and checks every result.
// Depends on wps_pkg and the core RTL.
`timescale 1ns / 1ps

module wavefunction_position_statistics_core_tb;

  localparam longint unsigned Cap42 = (64'd1 << 42) - 1;
  localparam longint unsigned Cap47 = (64'd1 << 47) - 1;
  localparam longint unsigned Cap48 = (64'd1 << 48) - 1;
  localparam longint FirstMax = (64'sd1 <<< 57) - 1;
  localparam longint FirstMin = -(64'sd1 <<< 57);
  localparam int StallLimit = 4000;
  localparam int RandomItems = 630;

  class wps_scoreboard;
    logic [15:0] dx;
    logic signed [15:0] lo_bound, hi_bound;
    longint unsigned norm_acc, window_acc, second_acc;
    longint first_acc;
    int unsigned count;
    wps_pkg::out_item_t stats_q[$];
    int errors;

    function new();
      dx = wps_pkg::GridStepReset;
      lo_bound = wps_pkg::IntervalLowReset;
      hi_bound = wps_pkg::IntervalHighReset;
      clear_sums();
      errors = 0;
    endfunction

    function void clear_sums();
      norm_acc = 0;
      window_acc = 0;
      second_acc = 0;
      first_acc = 0;
      count = 0;
    endfunction

    function void write_reg(logic [wps_pkg::CfgIdxBits-1:0] idx, logic [15:0] d);
      case (idx)
        wps_pkg::CFG_GRID_STEP: dx = d;
        wps_pkg::CFG_INTERVAL_LOW: lo_bound = d;
        wps_pkg::CFG_INTERVAL_HIGH: hi_bound = d;
        default: ;
      endcase
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // floor(a * b / 2^sh), clamped at cap without overflowing 64 bits.
    function longint unsigned scale(longint unsigned a, longint unsigned b, int sh,
                                    longint unsigned cap);
      longint unsigned hi, lo, t, u;
      hi = a >> sh;
      lo = a & ((64'd1 << sh) - 1);
      if (b == 0) return 0;
      if (hi > cap / b) return cap;
      t = hi * b;
      u = (lo * b) >> sh;
      if (t > cap - u) return cap;
      return t + u;
    endfunction

    function longint unsigned recip_root(longint unsigned n);
      longint unsigned lim;
      if (n == 0) return 0;
      if (n == 1) return 64'hFFFF_FFFF;
      lim = 64'hFFFF_FFFF_FFFF_FFFF / n;
      if (64'hFFFF_FFFF_FFFF_FFFF % n == n - 1) lim = lim + 1;
      return isqrt(lim);
    endfunction

    function void note_sample(wps_pkg::in_item_t s);
      longint re, im, x, sq, xp, sum;
      longint unsigned ax, x2p, nrm, msq, mmag, ah, al, m2, var_v;
      logic neg;
      wps_pkg::out_item_t e;
      re = s.psi_re;
      im = s.psi_im;
      x = s.position;
      sq = re * re + im * im;
      norm_acc = (norm_acc + sq > Cap42) ? Cap42 : norm_acc + sq;
      if (s.position >= lo_bound && s.position <= hi_bound)
        window_acc = (window_acc + sq > Cap42) ? Cap42 : window_acc + sq;
      xp = x * sq;
      sum = first_acc + xp;
      first_acc = (sum > FirstMax) ? FirstMax : ((sum < FirstMin) ? FirstMin : sum);
      ax = (x < 0) ? -x : x;
      x2p = ax * ax * longint'(sq);
      second_acc = (second_acc > 64'hFFFF_FFFF_FFFF_FFFF - x2p) ?
                   64'hFFFF_FFFF_FFFF_FFFF : second_acc + x2p;
      if (count < wps_pkg::MaxSamplesDefault) count++;
      if (!s.last_sample) return;

      nrm = scale(norm_acc, dx, wps_pkg::ShNorm, Cap48);
      msq = scale(second_acc, dx, wps_pkg::ShSecond, Cap48);
      if (first_acc < 0) begin
        mmag = scale(-first_acc, dx, wps_pkg::ShFirst, Cap47 + 1);
        e.mean_position = 48'(-mmag);
      end else begin
        mmag = scale(first_acc, dx, wps_pkg::ShFirst, Cap47);
        e.mean_position = 48'(mmag);
      end
      ah = mmag >> 32;
      al = mmag & 64'hFFFF_FFFF;
      m2 = ((ah * ah) << 32) + 2 * ah * al + ((al * al) >> 32);
      neg = m2 > msq;
      var_v = neg ? 0 : msq - m2;
      e.norm_squared = 48'(nrm);
      e.inverse_norm = 32'(recip_root(nrm));
      e.interval_probability = 48'(scale(window_acc, dx, wps_pkg::ShNorm, Cap48));
      e.mean_square_position = 48'(msq);
      e.position_spread = 32'(isqrt(var_v));
      e.norm_zero = (nrm == 0);
      e.variance_negative = neg;
      e.samples_seen = 11'(count);
      stats_q.push_back(e);
      clear_sums();
    endfunction

    function void check_result(wps_pkg::out_item_t r);
      wps_pkg::out_item_t e;
      if (stats_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = stats_q.pop_front();
      if (r.norm_squared !== e.norm_squared) begin
        $error("norm_squared: expected %0d, got %0d", e.norm_squared, r.norm_squared);
        errors++;
      end
      if (r.inverse_norm !== e.inverse_norm) begin
        $error("inverse_norm: expected %0d, got %0d", e.inverse_norm, r.inverse_norm);
        errors++;
      end
      if (r.interval_probability !== e.interval_probability) begin
        $error("interval_probability: expected %0d, got %0d",
               e.interval_probability, r.interval_probability);
        errors++;
      end
      if (r.mean_position !== e.mean_position) begin
        $error("mean_position: expected %0d, got %0d", e.mean_position, r.mean_position);
        errors++;
      end
      if (r.mean_square_position !== e.mean_square_position) begin
        $error("mean_square_position: expected %0d, got %0d",
               e.mean_square_position, r.mean_square_position);
        errors++;
      end
      if (r.position_spread !== e.position_spread) begin
        $error("position_spread: expected %0d, got %0d",
               e.position_spread, r.position_spread);
        errors++;
      end
      if (r.norm_zero !== e.norm_zero) begin
        $error("norm_zero: expected %0d, got %0d", e.norm_zero, r.norm_zero);
        errors++;
      end
      if (r.variance_negative !== e.variance_negative) begin
        $error("variance_negative: expected %0d, got %0d",
               e.variance_negative, r.variance_negative);
        errors++;
      end
      if (r.samples_seen !== e.samples_seen) begin
        $error("samples_seen: expected %0d, got %0d", e.samples_seen, r.samples_seen);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  wps_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  wps_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [wps_pkg::CfgIdxBits-1:0] cfg_index = wps_pkg::CFG_GRID_STEP;
  logic [15:0] cfg_data = '0;

  wps_scoreboard stats_sb = new();
  int results_seen = 0;
  int idle_cycles = 0;
  bit quiet_mode = 0;

  always #5 clk = ~clk;

  wavefunction_position_statistics_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // DUT registers update after this block reads them, so sampling here is race free.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) stats_sb.note_sample(in_data);
      if (out_valid && out_ready) begin
        stats_sb.check_result(out_data);
        results_seen++;
      end
      if (cfg_valid && cfg_ready) stats_sb.write_reg(cfg_index, cfg_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random back-pressure plus one long hold once results are flowing.
  initial begin : receiver
    int n;
    bit held;
    held = 0;
    forever begin
      if (!held && results_seen >= 40) begin
        held = 1;
        repeat (400) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      n = gap_len();
      repeat (n) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
    end
  end

  task automatic send_sample(logic [15:0] re, logic [15:0] im, logic [15:0] pos,
                             logic last);
    wps_pkg::in_item_t s;
    int n;
    s.psi_re = re;
    s.psi_im = im;
    s.position = pos;
    s.last_sample = last;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = gap_len();
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (stats_sb.stats_q.size() != 0) @(posedge clk);
    // A sample without last may still be in the back end.
    repeat (150) @(posedge clk);
  endtask

  task automatic write_cfg(logic [wps_pkg::CfgIdxBits-1:0] idx, logic [15:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] step, logic [15:0] lo, logic [15:0] hi);
    drain();
    write_cfg(wps_pkg::CFG_GRID_STEP, step);
    write_cfg(wps_pkg::CFG_INTERVAL_LOW, lo);
    write_cfg(wps_pkg::CFG_INTERVAL_HIGH, hi);
  endtask

  // One wavefunction with random content; amplitude and position ranges vary.
  task automatic send_wave(int len);
    int amp_mode, pos_mode;
    logic [15:0] re, im, pos;
    amp_mode = $urandom_range(0, 3);
    pos_mode = $urandom_range(0, 2);
    for (int i = 0; i < len; i++) begin
      case (amp_mode)
        0: begin
          re = 16'($urandom_range(0, 65535));
          im = 16'($urandom_range(0, 65535));
        end
        1: begin
          re = 16'($urandom_range(0, 127)) - 16'd64;
          im = 16'($urandom_range(0, 127)) - 16'd64;
        end
        2: begin
          re = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
          im = 16'd0;
        end
        default: begin
          re = 16'($urandom_range(0, 15));
          im = 16'($urandom_range(0, 15));
        end
      endcase
      if (pos_mode == 0) pos = 16'($urandom_range(0, 65535));
      else if (pos_mode == 1) pos = 16'($urandom_range(0, 1023)) - 16'd512;
      else pos = 16'($urandom_range(0, 7)) * 16'd256 - 16'd1024;
      send_sample(re, im, pos, i == len - 1);
    end
  endtask

  initial begin : stimulus
    int sent, len;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, extremes and zero norm.
    send_sample(16'd0, 16'd0, 16'd0, 1'b1);
    send_sample(16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    send_sample(16'h7FFF, 16'd0, -16'sd256, 1'b0);
    send_sample(16'h7FFF, 16'd0, 16'd256, 1'b1);
    send_sample(16'd1, 16'd0, 16'd0, 1'b1);
    // Smallest nonzero norm saturates the reciprocal.
    set_config(16'd1, 16'h8000, 16'h7FFF);
    send_sample(16'd8, 16'd0, 16'd0, 1'b1);
    send_sample(16'd0, 16'd0, 16'd5, 1'b1);
    // Zero grid step zeroes every scaled sum.
    set_config(16'd0, 16'h8000, 16'h7FFF);
    send_sample(16'd1000, 16'd1000, 16'd5, 1'b1);
    // Empty interval: low above high.
    set_config(16'hFFFF, 16'd100, -16'sd100);
    send_sample(16'h7FFF, 16'h8000, 16'd0, 1'b0);
    send_sample(16'h1234, 16'h4321, 16'd100, 1'b0);
    send_sample(16'h8000, 16'h7FFF, 16'h7FFF, 1'b1);
    // Interval edges are inclusive.
    set_config(16'd256, -16'sd256, 16'd256);
    send_sample(16'd3000, 16'd0, -16'sd256, 1'b0);
    send_sample(16'd3000, 16'd0, 16'd256, 1'b0);
    send_sample(16'd3000, 16'd0, 16'd257, 1'b0);
    send_sample(16'd3000, 16'd0, -16'sd257, 1'b1);

    sent = 0;
    while (sent < RandomItems) begin
      if (sent % 110 == 0) begin
        case ($urandom_range(0, 3))
          0: set_config(16'hFFFF, 16'h8000, 16'h7FFF);
          1: set_config(16'd1, 16'h7FFF, 16'h8000);
          default: set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)));
        endcase
        quiet_mode = ($urandom_range(0, 2) == 0);
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      send_wave(len);
      sent += len;
    end

    drain();
    if (stats_sb.errors == 0 && stats_sb.stats_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
